/* design/band_ratio_squelch_unit_defines.svh */
// Assertion shorthands for the squelch unit; they expect clk and arst_n in scope.
`ifndef BAND_RATIO_SQUELCH_UNIT_DEFINES_SVH
`define BAND_RATIO_SQUELCH_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("squelch unit: next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define BRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("squelch unit: same-cycle check failed");

`endif

/* design/brs_pkg.sv */
package brs_pkg;

	localparam int BinW                = 6;
	localparam int SmpW                = 8;
	localparam int LevelW              = 7;
	localparam int AccW                = 22;
	localparam int PowW                = 16;
	localparam int SumOutW             = 25;
	localparam int CfgIdxW             = 3;
	localparam int CfgDataW            = 7;
	localparam int BinsPerFrame        = 64;
	localparam int HistoryDepthDefault = 8;

	// accumulator ceiling, leaves room for the +1 on the frame total
	localparam logic [AccW-1:0] AccMax = 22'h3FFFFE;

	typedef enum logic [CfgIdxW-1:0] {
		CfgLowFirst  = 3'd0,
		CfgLowLast   = 3'd1,
		CfgHighFirst = 3'd2,
		CfgHighLast  = 3'd3,
		CfgHoldMax   = 3'd4,
		CfgAttack    = 3'd5
	} brs_cfg_idx_t;

	typedef struct packed {
		logic [BinW-1:0]   low_first_bin;
		logic [BinW-1:0]   low_last_bin;
		logic [BinW-1:0]   high_first_bin;
		logic [BinW-1:0]   high_last_bin;
		logic [LevelW-1:0] hold_max;
		logic [LevelW-1:0] attack_step;
	} brs_cfg_t;

	typedef struct packed {
		logic [BinW-1:0]        bin_index;
		logic signed [SmpW-1:0] bin_real;
		logic signed [SmpW-1:0] bin_imag;
		logic                   frame_end;
	} brs_in_t;

	typedef struct packed {
		logic [SumOutW-1:0] low_power_sum;
		logic [SumOutW-1:0] high_power_sum;
		logic [LevelW-1:0]  hold_level;
		logic               squelch_open;
	} brs_out_t;

	typedef struct packed {
		logic [AccW-1:0] low_total;
		logic [AccW-1:0] high_total;
	} brs_tot_t;

endpackage

/* design/band_ratio_squelch_unit.sv */
// A frame-end bin passes through registered stages s1, s2, s3 (accumulator), s4 (history) and s5, s6 (level).
// Throughput: one bin per cycle unless stalled; the accumulator and level loops each close through one register.
// Only frame-end bins produce a result; res_stall backs up through registered stages.
// Reset clears accumulators, histories, running sums, level and flag, and loads the
// default band edges, hold_max and attack_step; the block is ready the cycle after reset.
`include "band_ratio_squelch_unit_defines.svh"

module band_ratio_squelch_unit #(
	parameter int HISTORY_DEPTH = brs_pkg::HistoryDepthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [brs_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [brs_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          bin_valid,
	output logic                          bin_stall,
	input  brs_pkg::brs_in_t              bin,
	output logic                          res_valid,
	input  logic                          res_stall,
	output brs_pkg::brs_out_t             res
);
	import brs_pkg::*;

	localparam int SumW = AccW + $clog2(HISTORY_DEPTH);

	brs_cfg_t        cfg_q;
	logic            tot_valid, tot_stall;
	brs_tot_t        tot;
	logic            sum_valid, sum_stall;
	logic [SumW-1:0] low_sum, high_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_first_bin  <= 6'd5;
			cfg_q.low_last_bin   <= 6'd9;
			cfg_q.high_first_bin <= 6'd19;
			cfg_q.high_last_bin  <= 6'd24;
			cfg_q.hold_max       <= 7'd100;
			cfg_q.attack_step    <= 7'd34;
		end else if (cfg_we) begin
			case (brs_cfg_idx_t'(cfg_index))
				CfgLowFirst:  cfg_q.low_first_bin  <= cfg_data[BinW-1:0];
				CfgLowLast:   cfg_q.low_last_bin   <= cfg_data[BinW-1:0];
				CfgHighFirst: cfg_q.high_first_bin <= cfg_data[BinW-1:0];
				CfgHighLast:  cfg_q.high_last_bin  <= cfg_data[BinW-1:0];
				CfgHoldMax:   cfg_q.hold_max       <= cfg_data[LevelW-1:0];
				CfgAttack:    cfg_q.attack_step    <= cfg_data[LevelW-1:0];
				default: ;
			endcase
		end
	end

	brs_band_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin       (bin),
		.tot_valid (tot_valid),
		.tot_stall (tot_stall),
		.tot       (tot)
	);

	brs_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.tot_valid (tot_valid),
		.tot_stall (tot_stall),
		.tot       (tot),
		.sum_valid (sum_valid),
		.sum_stall (sum_stall),
		.low_sum   (low_sum),
		.high_sum  (high_sum)
	);

	brs_level #(
		.SumW (SumW)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sum_valid (sum_valid),
		.sum_stall (sum_stall),
		.low_sum   (low_sum),
		.high_sum  (high_sum),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// a held frame total or history sum must not be lost or altered
	`BRS_ASSERT_NEXT(a_tot_held, tot_valid && tot_stall, tot_valid && $stable(tot))
	`BRS_ASSERT_NEXT(a_sum_held, sum_valid && sum_stall, sum_valid && $stable({low_sum, high_sum}))

endmodule

/* design/brs_band_accum.sv */
module brs_band_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  brs_pkg::brs_cfg_t cfg,
	input  logic              bin_valid,
	output logic              bin_stall,
	input  brs_pkg::brs_in_t  bin,
	output logic              tot_valid,
	input  logic              tot_stall,
	output brs_pkg::brs_tot_t tot
);
	import brs_pkg::*;

	logic                valid_s1;
	brs_in_t             in_s1;
	logic                valid_s2;
	logic [PowW-1:0]     power_s2;
	logic                low_hit_s2;
	logic                high_hit_s2;
	logic                end_s2;
	logic                tot_valid_s3;
	brs_tot_t            tot_s3;
	logic [AccW-1:0]     acc_low_q;
	logic [AccW-1:0]     acc_high_q;

	logic                ready1, ready2, ready3, fire2;
	logic signed [15:0]  re_sq, im_sq;
	logic [PowW-1:0]     power;
	logic                in_frame, low_hit, high_hit;
	logic [AccW:0]       sum_low, sum_high;
	logic [AccW-1:0]     sat_low, sat_high;

	// only frame-end requests leave this block
	assign ready3    = !tot_valid_s3 || !tot_stall;
	assign ready2    = !valid_s2 || !end_s2 || ready3;
	assign ready1    = !valid_s1 || ready2;
	assign fire2     = valid_s2 && ready2;
	assign bin_stall = !ready1;
	assign tot_valid = tot_valid_s3;
	assign tot       = tot_s3;

	always_comb begin
		re_sq    = in_s1.bin_real * in_s1.bin_real;
		im_sq    = in_s1.bin_imag * in_s1.bin_imag;
		power    = {1'b0, re_sq[14:0]} + {1'b0, im_sq[14:0]};
		in_frame = 32'(in_s1.bin_index) < 32'(BinsPerFrame);
		low_hit  = in_frame && (in_s1.bin_index >= cfg.low_first_bin)
			&& (in_s1.bin_index <= cfg.low_last_bin);
		high_hit = in_frame && (in_s1.bin_index >= cfg.high_first_bin)
			&& (in_s1.bin_index <= cfg.high_last_bin);
	end

	always_comb begin
		sum_low  = {1'b0, acc_low_q} + (low_hit_s2 ? (AccW+1)'(power_s2) : '0);
		sum_high = {1'b0, acc_high_q} + (high_hit_s2 ? (AccW+1)'(power_s2) : '0);
		sat_low  = (sum_low > {1'b0, AccMax}) ? AccMax : sum_low[AccW-1:0];
		sat_high = (sum_high > {1'b0, AccMax}) ? AccMax : sum_high[AccW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			tot_valid_s3 <= 1'b0;
			acc_low_q    <= '0;
			acc_high_q   <= '0;
		end else begin
			if (ready1) valid_s1 <= bin_valid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) tot_valid_s3 <= valid_s2 && end_s2;
			if (fire2) begin
				acc_low_q  <= end_s2 ? '0 : sat_low;
				acc_high_q <= end_s2 ? '0 : sat_high;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && bin_valid) in_s1 <= bin;
		if (ready2 && valid_s1) begin
			power_s2    <= power;
			low_hit_s2  <= low_hit;
			high_hit_s2 <= high_hit;
			end_s2      <= in_s1.frame_end;
		end
		if (ready3 && fire2 && end_s2) begin
			tot_s3.low_total  <= sat_low + AccW'(1);
			tot_s3.high_total <= sat_high + AccW'(1);
		end
	end

endmodule

/* design/brs_history.sv */
module brs_history #(
	parameter int HISTORY_DEPTH = brs_pkg::HistoryDepthDefault,
	localparam int SumW = brs_pkg::AccW + $clog2(HISTORY_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tot_valid,
	output logic              tot_stall,
	input  brs_pkg::brs_tot_t tot,
	output logic              sum_valid,
	input  logic              sum_stall,
	output logic [SumW-1:0]   low_sum,
	output logic [SumW-1:0]   high_sum
);
	import brs_pkg::*;

	logic [AccW-1:0] low_hist_q  [HISTORY_DEPTH];
	logic [AccW-1:0] high_hist_q [HISTORY_DEPTH];
	logic [SumW-1:0] low_run_q, high_run_q;
	logic [SumW-1:0] low_run_next, high_run_next;
	logic            sum_valid_s4;
	logic [SumW-1:0] low_sum_s4, high_sum_s4;
	logic            ready4, fire;

	assign ready4    = !sum_valid_s4 || !sum_stall;
	assign tot_stall = sum_valid_s4 && sum_stall;
	assign fire      = tot_valid && ready4;
	assign sum_valid = sum_valid_s4;
	assign low_sum   = low_sum_s4;
	assign high_sum  = high_sum_s4;

	// running sum: drop the oldest entry, add the incoming total
	assign low_run_next  = low_run_q - SumW'(low_hist_q[HISTORY_DEPTH-1])
		+ SumW'(tot.low_total);
	assign high_run_next = high_run_q - SumW'(high_hist_q[HISTORY_DEPTH-1])
		+ SumW'(tot.high_total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				low_hist_q[i]  <= '0;
				high_hist_q[i] <= '0;
			end
			low_run_q    <= '0;
			high_run_q   <= '0;
			sum_valid_s4 <= 1'b0;
		end else begin
			if (ready4) sum_valid_s4 <= tot_valid;
			if (fire) begin
				for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
					low_hist_q[i]  <= low_hist_q[i-1];
					high_hist_q[i] <= high_hist_q[i-1];
				end
				low_hist_q[0]  <= tot.low_total;
				high_hist_q[0] <= tot.high_total;
				low_run_q      <= low_run_next;
				high_run_q     <= high_run_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			low_sum_s4  <= low_run_next;
			high_sum_s4 <= high_run_next;
		end
	end

endmodule

/* design/brs_level.sv */
module brs_level #(
	parameter int SumW = brs_pkg::AccW + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brs_pkg::brs_cfg_t cfg,
	input  logic              sum_valid,
	output logic              sum_stall,
	input  logic [SumW-1:0]   low_sum,
	input  logic [SumW-1:0]   high_sum,
	output logic              res_valid,
	input  logic              res_stall,
	output brs_pkg::brs_out_t res
);
	import brs_pkg::*;

	localparam int CmpW = SumW + 3;

	logic               valid_s5, rise_s5, fall_s5;
	logic [SumOutW-1:0] low_sum_s5, high_sum_s5;
	logic               res_valid_s6;
	brs_out_t           res_s6;
	logic [LevelW-1:0]  level_q;
	logic               open_q;

	logic               ready5, ready6, fire5;
	logic [CmpW-1:0]    low_ext, high_ext, low_x3, low_x5, high_x5, high_x6;
	logic [LevelW:0]    raised;
	logic [LevelW-1:0]  level_next;
	logic               open_next;

	assign ready6    = !res_valid_s6 || !res_stall;
	assign ready5    = !valid_s5 || ready6;
	assign fire5     = valid_s5 && ready6;
	assign sum_stall = valid_s5 && !ready6;
	assign res_valid = res_valid_s6;
	assign res       = res_s6;

	// ratio tests by shift and add
	always_comb begin
		low_ext  = CmpW'(low_sum);
		high_ext = CmpW'(high_sum);
		low_x3   = (low_ext << 1) + low_ext;
		low_x5   = (low_ext << 2) + low_ext;
		high_x5  = (high_ext << 2) + high_ext;
		high_x6  = (high_ext << 2) + (high_ext << 1);
	end

	always_comb begin
		raised     = {1'b0, level_q} + {1'b0, cfg.attack_step};
		level_next = level_q;
		if (rise_s5) begin
			level_next = (raised > {1'b0, cfg.hold_max}) ? cfg.hold_max : raised[LevelW-1:0];
		end else if (fall_s5 && level_q != '0) begin
			level_next = level_q - LevelW'(1);
		end
		// the hold_max match wins over the zero match
		if (level_next == cfg.hold_max) begin
			open_next = 1'b1;
		end else if (level_next == '0) begin
			open_next = 1'b0;
		end else begin
			open_next = open_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5     <= 1'b0;
			res_valid_s6 <= 1'b0;
			level_q      <= '0;
			open_q       <= 1'b0;
		end else begin
			if (ready5) valid_s5 <= sum_valid;
			if (ready6) res_valid_s6 <= valid_s5;
			if (fire5) begin
				level_q <= level_next;
				open_q  <= open_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready5 && sum_valid) begin
			rise_s5     <= low_x3 > high_x5;
			fall_s5     <= low_x5 < high_x6;
			low_sum_s5  <= SumOutW'(low_sum);
			high_sum_s5 <= SumOutW'(high_sum);
		end
		if (fire5) begin
			res_s6.low_power_sum  <= low_sum_s5;
			res_s6.high_power_sum <= high_sum_s5;
			res_s6.hold_level     <= level_next;
			res_s6.squelch_open   <= open_next;
		end
	end

endmodule
